@@ rtl/mccu_pkg.sv @@
package mccu_pkg;

    localparam int unsigned CTRL_COUNT = 128;
    localparam int unsigned CTRL_AW    = $clog2(CTRL_COUNT);

    // controller numbers with special handling
    localparam logic [6:0] CC_BANK_HI   = 7'd0;
    localparam logic [6:0] CC_DATA_MSB  = 7'd6;
    localparam logic [6:0] CC_BANK_LO   = 7'd32;
    localparam logic [6:0] CC_LSB_FIRST = 7'd33;
    localparam logic [6:0] CC_LSB_LAST  = 7'd45;
    localparam logic [6:0] CC_DATA_LSB  = 7'd38;
    localparam logic [6:0] CC_SUSTAIN   = 7'd64;
    localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
    localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_RPN_MSB   = 7'd101;
    localparam logic [6:0] CC_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_RESET_ALL = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF = 7'd123;

    localparam logic [6:0] LSB_OFFSET   = 7'd32;
    localparam logic [6:0] SF2_NRPN_SEL = 7'd120;
    localparam logic [6:0] XG_DRUM_BANK = 7'd127;
    localparam logic [6:0] XG_SFX_BANK  = 7'd120;
    localparam logic [3:0] XG_DRUM_CHAN = 4'd9;
    localparam logic [6:0] SUSTAIN_ON   = 7'd64;

    localparam logic [6:0]  GEN_STEP_LIMIT = 7'd100;
    localparam logic [6:0]  GEN_SEL_100    = 7'd100;
    localparam logic [6:0]  GEN_SEL_1000   = 7'd101;
    localparam logic [6:0]  GEN_SEL_10000  = 7'd102;
    localparam logic [13:0] GEN_ADD_100    = 14'd100;
    localparam logic [13:0] GEN_ADD_1000   = 14'd1000;
    localparam logic [13:0] GEN_ADD_10000  = 14'd10000;
    localparam logic [15:0] GEN_MAX        = 16'hffff;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_RECOMPUTE   = 3'd1,
        ACT_NOTES_OFF   = 3'd2,
        ACT_SOUND_OFF   = 3'd3,
        ACT_ENTRY_HI    = 3'd4,
        ACT_ENTRY_LO    = 3'd5,
        ACT_RELEASE_SUS = 3'd6,
        ACT_RESET_ALL   = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ENTRY_IDLE     = 3'd0,
        ENTRY_RPN_HI   = 3'd1,
        ENTRY_RPN_LO   = 3'd2,
        ENTRY_NRPN_HI  = 3'd3,
        ENTRY_NRPN_LO  = 3'd4
    } t_entry;

    typedef enum logic [1:0] {
        CFG_XG_MODE   = 2'd0,
        CFG_CHANNEL   = 2'd1,
        CFG_LOCK_LOW  = 2'd2,
        CFG_LOCK_HIGH = 2'd3
    } t_cfg_reg;

endpackage

@@ rtl/mccu_if.sv @@
interface mccu_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] controller_number;
    logic [6:0] control_value;

    modport source (output valid, controller_number, control_value, input ready);
    modport sink   (input valid, controller_number, control_value, output ready);
endinterface

interface mccu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [6:0]  action_value;
    logic [13:0] controller_value;
    logic [2:0]  entry_mode;
    logic [6:0]  bank_high;
    logic [6:0]  bank_low;
    logic        is_drum;
    logic [15:0] generator_select;

    modport source (output valid, action, action_value, controller_value, entry_mode,
                    bank_high, bank_low, is_drum, generator_select, input ready);
    modport sink   (input valid, action, action_value, controller_value, entry_mode,
                    bank_high, bank_low, is_drum, generator_select, output ready);
endinterface

interface mccu_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/midi_channel_controller_update.sv @@
// channel  | dir | handshake    | payload
// i_in     | in  | valid/ready  | controller_number, control_value
// o_out    | out | valid/ready  | action, action_value, controller_value, entry_mode,
//          |     |              | bank_high, bank_low, is_drum, generator_select
// i_cfg    | in  | valid/ready  | index, data (register write, always ready)
//
// one request per cycle sustained while the output is not stalled; a result reaches the output
// register through the write-back stage (store read at the edge that takes its request, write-back
// and output load at the edge on which the write-back stage moves on)
// the 128 x 14 controller store is a one-port-write, registered-read memory;
// a store read that hits the entry being written in the same cycle is forwarded
// reset (synchronous, active low) clears control state and the store valid bits,
// so unwritten entries read as zero; no clearing pass is needed
// a stalled output holds the write-back stage, which in turn holds i_in.ready low
module midi_channel_controller_update
    import mccu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mccu_in_if.sink     i_in,
    mccu_out_if.source  o_out,
    mccu_cfg_if.sink    i_cfg
);

    // configuration registers
    logic        r_xg_mode;
    logic [5:0]  r_channel;
    logic [63:0] r_lock_low;
    logic [63:0] r_lock_high;

    // controller store and its valid bits
    logic [13:0]           r_store [CTRL_COUNT];
    logic [CTRL_COUNT-1:0] r_store_vld;

    // write-back stage
    logic               r_s1_vld;
    logic [6:0]         r_s1_cc;
    logic [6:0]         r_s1_val;
    logic               r_s1_lsb;
    logic [CTRL_AW-1:0] r_s1_addr;
    logic [13:0]        r_rd_q;
    logic               r_rd_vld;
    logic               r_fwd_hit;
    logic [13:0]        r_fwd_q;

    // channel state
    t_entry      r_entry;
    t_entry      n_entry;
    logic [6:0]  r_bank_hi;
    logic [6:0]  n_bank_hi;
    logic [6:0]  r_bank_lo;
    logic [6:0]  n_bank_lo;
    logic        r_drum;
    logic        n_drum;
    logic [15:0] r_gen;
    logic [15:0] n_gen;
    logic        r_gen_mult;   // r_gen is a multiple of 100
    logic        n_gen_mult;

    // output register
    logic        r_out_vld;
    t_action     r_out_act;
    logic [6:0]  r_out_val;
    logic [13:0] r_out_ctrl;

    // request-side decode
    logic [6:0]         in_cc;
    logic [6:0]         in_val;
    logic               in_lsb;
    logic [6:0]         in_primary;
    logic [127:0]       lock_all;
    logic               in_locked;
    logic [CTRL_AW-1:0] rd_addr;
    logic               in_take;
    logic               s1_go;

    // write-back decode
    logic [13:0]        old_entry;
    logic [13:0]        wr_data;
    logic [CTRL_AW-1:0] wr_addr;
    logic               wr_en;
    t_action            s1_act;
    logic [6:0]         bank_sel;
    logic [15:0]        gen_base;
    logic [13:0]        gen_add;
    logic [16:0]        gen_sum;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xg_mode   <= 1'b0;
            r_channel   <= '0;
            r_lock_low  <= '0;
            r_lock_high <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_XG_MODE:   r_xg_mode   <= i_cfg.data[0];
                CFG_CHANNEL:   r_channel   <= i_cfg.data[5:0];
                CFG_LOCK_LOW:  r_lock_low  <= i_cfg.data;
                CFG_LOCK_HIGH: r_lock_high <= i_cfg.data;
            endcase
        end
    end

    // a fine-resolution lsb merges into its primary, 32 below it
    assign in_cc      = i_in.controller_number;
    assign in_val     = i_in.control_value;
    assign in_lsb     = (in_cc >= CC_LSB_FIRST) && (in_cc <= CC_LSB_LAST)
                        && (in_cc != CC_DATA_LSB);
    assign in_primary = in_lsb ? (in_cc - LSB_OFFSET) : in_cc;
    assign lock_all   = {r_lock_high, r_lock_low};
    assign in_locked  = lock_all[in_cc] || (in_lsb && lock_all[in_primary]);

    // nrpn lsb needs the stored nrpn msb; everything else reads its primary
    assign rd_addr = (in_cc == CC_NRPN_LSB) ? CC_NRPN_MSB[CTRL_AW-1:0]
                                            : in_primary[CTRL_AW-1:0];

    assign s1_go      = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_s1_vld || s1_go;
    assign in_take    = i_in.valid && i_in.ready && !in_locked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_take) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cc   <= in_cc;
            r_s1_val  <= in_val;
            r_s1_lsb  <= in_lsb;
            r_s1_addr <= rd_addr;
            r_rd_vld  <= r_store_vld[rd_addr];
            r_fwd_hit <= wr_en && (wr_addr == rd_addr);
            r_fwd_q   <= wr_data;
        end
    end

    // store: registered read at request time, write-back one stage later
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rd_q <= r_store[rd_addr];
        end
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_vld <= '0;
        end else if (wr_en) begin
            r_store_vld[wr_addr] <= 1'b1;
        end
    end

    assign old_entry = r_fwd_hit ? r_fwd_q : (r_rd_vld ? r_rd_q : 14'd0);

    // a merged lsb writes only its primary: the lsb's own entry is never read back
    assign wr_en   = r_s1_vld && s1_go;
    assign wr_addr = r_s1_lsb ? r_s1_addr : r_s1_cc[CTRL_AW-1:0];
    assign wr_data = r_s1_lsb ? {old_entry[13:7], r_s1_val} : {r_s1_val, 7'd0};

    always_comb begin
        unique case (r_s1_cc) inside
            CC_NOTES_OFF: s1_act = ACT_NOTES_OFF;
            CC_SOUND_OFF: s1_act = ACT_SOUND_OFF;
            CC_BANK_HI, CC_BANK_LO, CC_RPN_LSB, CC_RPN_MSB,
            CC_NRPN_MSB, CC_NRPN_LSB: s1_act = ACT_NONE;
            CC_DATA_MSB:  s1_act = ACT_ENTRY_HI;
            CC_DATA_LSB:  s1_act = ACT_ENTRY_LO;
            CC_SUSTAIN:   s1_act = (r_s1_val < SUSTAIN_ON) ? ACT_RELEASE_SUS : ACT_NONE;
            CC_RESET_ALL: s1_act = ACT_RESET_ALL;
            default:      s1_act = ACT_RECOMPUTE;
        endcase
    end

    // sf2 generator select: 100 / 1000 / 10000 for values 100..102, the value below 100, else zero
    always_comb begin
        if (r_s1_val == GEN_SEL_100) begin
            gen_add = GEN_ADD_100;
        end else if (r_s1_val == GEN_SEL_1000) begin
            gen_add = GEN_ADD_1000;
        end else if (r_s1_val == GEN_SEL_10000) begin
            gen_add = GEN_ADD_10000;
        end else if (r_s1_val < GEN_STEP_LIMIT) begin
            gen_add = {7'd0, r_s1_val};
        end else begin
            gen_add = '0;
        end
    end

    assign gen_base = r_gen_mult ? r_gen : 16'd0;
    assign gen_sum  = {1'b0, gen_base} + {3'd0, gen_add};
    assign bank_sel = (r_xg_mode && (r_channel[3:0] == XG_DRUM_CHAN)) ? XG_DRUM_BANK
                                                                      : r_s1_val;

    always_comb begin
        n_entry    = r_entry;
        n_bank_hi  = r_bank_hi;
        n_bank_lo  = r_bank_lo;
        n_drum     = r_drum;
        n_gen      = r_gen;
        n_gen_mult = r_gen_mult;
        case (r_s1_cc)
            CC_BANK_HI: begin
                n_bank_hi = bank_sel;
                if (r_xg_mode) begin
                    n_drum = (bank_sel == XG_SFX_BANK) || (bank_sel == XG_DRUM_BANK);
                end
            end
            CC_BANK_LO:  n_bank_lo = r_s1_val;
            CC_RPN_LSB:  n_entry = ENTRY_RPN_LO;
            CC_RPN_MSB:  n_entry = ENTRY_RPN_HI;
            CC_NRPN_MSB: begin
                n_entry    = ENTRY_NRPN_HI;
                n_gen      = '0;
                n_gen_mult = 1'b1;
            end
            CC_NRPN_LSB: begin
                n_entry = ENTRY_NRPN_LO;
                if (old_entry[13:7] == SF2_NRPN_SEL) begin
                    if (gen_sum[16]) begin
                        n_gen      = GEN_MAX;
                        n_gen_mult = 1'b0;
                    end else begin
                        n_gen      = gen_sum[15:0];
                        // base is a multiple of 100, so only a small nonzero step breaks it
                        n_gen_mult = (r_s1_val >= GEN_STEP_LIMIT) || (r_s1_val == 7'd0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry    <= ENTRY_IDLE;
            r_bank_hi  <= '0;
            r_bank_lo  <= '0;
            r_drum     <= 1'b0;
            r_gen      <= '0;
            r_gen_mult <= 1'b1;
        end else if (wr_en) begin
            r_entry    <= n_entry;
            r_bank_hi  <= n_bank_hi;
            r_bank_lo  <= n_bank_lo;
            r_drum     <= n_drum;
            r_gen      <= n_gen;
            r_gen_mult <= n_gen_mult;
        end
    end

    // output register; the channel state registers double as its state fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_act  <= s1_act;
            r_out_val  <= r_s1_val;
            r_out_ctrl <= wr_data;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.action           = r_out_act;
    assign o_out.action_value     = r_out_val;
    assign o_out.controller_value = r_out_ctrl;
    assign o_out.entry_mode       = r_entry;
    assign o_out.bank_high        = r_bank_hi;
    assign o_out.bank_low         = r_bank_lo;
    assign o_out.is_drum          = r_drum;
    assign o_out.generator_select = r_gen;

endmodule
